FILE: rtl/core/fhcp_pkg.sv
// ----------------------------------------------------------------------------
// fhcp_pkg - shared types and constants of the FITS header card parser
// Character codes, column marks, parse phases and the per-word result record.
// ----------------------------------------------------------------------------
package fhcp_pkg;

  // Width of the saturating data offset before it is clipped to 32 bits.
  localparam int OFFSET_BITS = 32;

  localparam int CARD_LEN        = 80;
  localparam int CARDS_PER_BLOCK = 36;
  localparam int BLOCK_BYTES     = 2880;
  localparam int BLOCK_CNT_W     = 21;
  localparam int PROD_W          = BLOCK_CNT_W + 1 + 12;

  localparam logic [BLOCK_CNT_W-1:0] BLOCK_MAX = {BLOCK_CNT_W{1'b1}};
  localparam logic [11:0]            BLOCK_BYTES_C = 12'(BLOCK_BYTES);
  localparam logic [PROD_W-1:0]      OFFSET_LIMIT =
      (OFFSET_BITS >= 32) ? PROD_W'(33'h0_FFFF_FFFF)
                          : ((PROD_W'(1) << OFFSET_BITS) - PROD_W'(1));

  // Printable range and characters of interest
  localparam logic [7:0] CH_LOW    = 8'd32;
  localparam logic [7:0] CH_HIGH   = 8'd126;
  localparam logic [6:0] CH_SPACE  = 7'h20;
  localparam logic [6:0] CH_EQUALS = 7'h3D;
  localparam logic [6:0] CH_QUOTE  = 7'h27;
  localparam logic [6:0] CH_SLASH  = 7'h2F;

  localparam logic [63:0] END_KEY = 64'h454E_4420_2020_2020;

  // Column marks
  localparam logic [6:0] COL_EQ_FIRST  = 7'd8;
  localparam logic [6:0] COL_EQ_SECOND = 7'd9;
  localparam logic [6:0] COL_LAST      = 7'(CARD_LEN - 1);
  localparam logic [6:0] COL_NONE      = 7'(CARD_LEN);
  localparam logic [5:0] CIB_LAST      = 6'(CARDS_PER_BLOCK - 1);

  typedef enum logic [2:0] {
    PH_KEY      = 3'd0,
    PH_SEEK     = 3'd1,
    PH_BARE     = 3'd2,
    PH_STR      = 3'd3,
    PH_QUOTE    = 3'd4,
    PH_AFTER    = 3'd5,
    PH_DONE_STR = 3'd6,
    PH_DONE     = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNTERM   = 2'd1,
    ST_TRAILING = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] data_offset;
    logic        is_end_card;
    logic [1:0]  status;
    logic [6:0]  comment_start;
    logic        value_is_string;
    logic [6:0]  value_end;
    logic [6:0]  value_start;
    logic        has_value;
    logic [63:0] key_text;
    logic        card_done;
    logic [6:0]  clean_char;
  } result_t;

endpackage

FILE: rtl/core/fhcp_card_scan.sv
// ----------------------------------------------------------------------------
// fhcp_card_scan - per-card parse state and result of one header byte
// Holds the column, keyword and value trackers; summarizes on column 79.
// ----------------------------------------------------------------------------
module fhcp_card_scan (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       byte_in,
  output fhcp_pkg::result_t res
);
  import fhcp_pkg::*;

  logic [6:0]             column;
  logic [63:0]            key_shift;
  phase_t                 parse_phase;
  logic                   equals_seen;
  logic [6:0]             start_col;
  logic [6:0]             last_nonspace_col;
  logic [6:0]             end_col;
  logic [6:0]             comment_col;
  logic [1:0]             card_status;
  logic [5:0]             card_in_block;
  logic [BLOCK_CNT_W-1:0] block_count;

  logic [6:0]  c;
  logic [63:0] key_n;
  phase_t      phase_n;
  logic        eq_n;
  logic [6:0]  start_n;
  logic [6:0]  lastns_n;
  logic [6:0]  end_n;
  logic [6:0]  comment_n;
  logic [1:0]  status_n;
  logic        last_col;
  logic        has;
  logic        str;
  logic        is_end;
  logic [6:0]  end_f;
  logic [6:0]  comment_f;
  logic [1:0]  status_f;

  logic [BLOCK_CNT_W:0] bc_plus;
  logic [PROD_W-1:0]    prod;
  logic [31:0]          offset;

  assign c        = (byte_in < CH_LOW || byte_in > CH_HIGH) ? CH_SPACE : byte_in[6:0];
  assign last_col = (column == COL_LAST);

  // Update the trackers with this byte
  always_comb begin
    key_n     = key_shift;
    phase_n   = parse_phase;
    eq_n      = equals_seen;
    start_n   = start_col;
    lastns_n  = last_nonspace_col;
    end_n     = end_col;
    comment_n = comment_col;
    status_n  = card_status;
    if (column < COL_EQ_FIRST) begin
      key_n = {key_shift[55:0], 1'b0, c};
    end else if (column == COL_EQ_FIRST) begin
      if (c == CH_EQUALS) begin
        eq_n = 1'b1;
      end else if (c == CH_SPACE) begin
        eq_n = 1'b0;
      end else begin
        eq_n    = 1'b0;
        phase_n = PH_DONE;
      end
    end else if (column == COL_EQ_SECOND) begin
      if (parse_phase == PH_KEY) begin
        eq_n    = equals_seen ? (c == CH_SPACE) : (c == CH_EQUALS);
        phase_n = eq_n ? PH_SEEK : PH_DONE;
      end
    end else begin
      case (parse_phase)
        PH_SEEK: begin
          if (c != CH_SPACE) begin
            start_n = column;
            if (c == CH_QUOTE) begin
              phase_n = PH_STR;
            end else begin
              phase_n  = PH_BARE;
              lastns_n = column;
            end
          end
        end
        PH_BARE: begin
          if (c == CH_SLASH) begin
            end_n     = last_nonspace_col;
            comment_n = column + 7'd1;
            phase_n   = PH_DONE;
          end else if (c != CH_SPACE) begin
            lastns_n = column;
          end
        end
        PH_STR: begin
          if (c == CH_QUOTE) phase_n = PH_QUOTE;
        end
        PH_QUOTE, PH_AFTER: begin
          if (parse_phase == PH_QUOTE && c == CH_QUOTE) begin
            phase_n = PH_STR;
          end else begin
            if (parse_phase == PH_QUOTE) end_n = column - 7'd1;
            if (c == CH_SLASH) begin
              comment_n = column + 7'd1;
              phase_n   = PH_DONE_STR;
            end else if (c != CH_SPACE) begin
              status_n = ST_TRAILING;
              phase_n  = PH_DONE_STR;
            end else begin
              phase_n = PH_AFTER;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Card summary on the last column
  always_comb begin
    has       = 1'b0;
    str       = 1'b0;
    res       = '0;
    end_f     = end_n;
    comment_f = comment_n;
    status_f  = status_n;
    case (phase_n)
      PH_BARE: begin
        end_f = lastns_n;
        has   = 1'b1;
      end
      PH_STR: begin
        status_f  = ST_UNTERM;
        end_f     = COL_LAST;
        comment_f = COL_NONE;
        has       = 1'b1;
        str       = 1'b1;
      end
      PH_QUOTE: begin
        end_f = COL_LAST;
        has   = 1'b1;
        str   = 1'b1;
      end
      PH_AFTER, PH_DONE_STR: begin
        has = 1'b1;
        str = 1'b1;
      end
      PH_DONE: has = eq_n;
      default: has = 1'b0;
    endcase
    if (!eq_n) has = 1'b0;
    if (status_f == ST_TRAILING) comment_f = COL_NONE;

    is_end  = (key_n == END_KEY);
    bc_plus = {1'b0, block_count} + (BLOCK_CNT_W+1)'(1);
    prod    = PROD_W'(bc_plus) * PROD_W'(BLOCK_BYTES_C);
    offset  = (block_count == BLOCK_MAX || prod > OFFSET_LIMIT) ?
              OFFSET_LIMIT[31:0] : prod[31:0];

    res.clean_char = c;
    if (last_col) begin
      res.card_done       = 1'b1;
      res.key_text        = key_n;
      res.has_value       = has;
      res.value_start     = has ? start_n : 7'd0;
      res.value_end       = has ? end_f : 7'd0;
      res.value_is_string = has && str;
      res.comment_start   = has ? comment_f : COL_NONE;
      res.status          = has ? status_f : ST_OK;
      res.is_end_card     = is_end;
      res.data_offset     = is_end ? offset : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column            <= '0;
      key_shift         <= '0;
      parse_phase       <= PH_KEY;
      equals_seen       <= 1'b0;
      start_col         <= '0;
      last_nonspace_col <= '0;
      end_col           <= '0;
      comment_col       <= COL_NONE;
      card_status       <= ST_OK;
      card_in_block     <= '0;
      block_count       <= '0;
    end else if (step) begin
      if (last_col) begin
        column            <= '0;
        key_shift         <= '0;
        parse_phase       <= PH_KEY;
        equals_seen       <= 1'b0;
        start_col         <= '0;
        last_nonspace_col <= '0;
        end_col           <= '0;
        comment_col       <= COL_NONE;
        card_status       <= ST_OK;
        if (is_end) begin
          card_in_block <= '0;
          block_count   <= '0;
        end else if (card_in_block == CIB_LAST) begin
          card_in_block <= '0;
          if (block_count != BLOCK_MAX) block_count <= block_count + BLOCK_CNT_W'(1);
        end else begin
          card_in_block <= card_in_block + 6'd1;
        end
      end else begin
        column            <= column + 7'd1;
        key_shift         <= key_n;
        parse_phase       <= phase_n;
        equals_seen       <= eq_n;
        start_col         <= start_n;
        last_nonspace_col <= lastns_n;
        end_col           <= end_n;
        comment_col       <= comment_n;
        card_status       <= status_n;
      end
    end
  end

endmodule

FILE: rtl/core/fits_header_card_parser.sv
// ----------------------------------------------------------------------------
// fits_header_card_parser - streaming FITS header card parser
// Cleans and echoes each header byte and summarizes every 80-byte card.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                          | Word
//  --------+----------------------------------+-------------------------------
//  in      | s_tvalid s_tready s_tdata[7:0]   | one raw header byte
//  out     | m_tvalid m_tready m_tdata m_tlast| cleaned byte plus card summary,
//          |                                  | tlast marks column 79 of a card
//
//  One word in, one word out. An input register holds the byte, the card
//  scanner updates its state from it and the result lands in the output
//  register. Both stages advance together whenever the output register is
//  empty or being taken, so a word is accepted every cycle while the sink
//  keeps up. A stall on m_tready holds the output register and a full input
//  register; an empty input register still takes one word. rst (synchronous)
//  empties the stages and returns the scanner to column 0 with a zero block
//  count.
//
module fits_header_card_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] byte_in
  output logic         m_tvalid,
  input  logic         m_tready,
  // [6:0] clean_char, [70:7] key_text, [71] has_value, [78:72] value_start,
  // [85:79] value_end, [86] value_is_string, [93:87] comment_start,
  // [95:94] status, [96] is_end_card, [128:97] data_offset, [135:129] zero
  output logic [135:0] m_tdata,
  output logic         m_tlast    // card_done
);
  import fhcp_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       step;
  result_t    res;
  result_t    out_res;

  // Move both stages when the output slot is free or emptying
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_byte <= s_tdata;
  end

  fhcp_card_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (in_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_res <= res;
  end

  // Pack the word, clean_char at the bottom; card_done rides on tlast
  assign m_tdata = {7'd0,
                    out_res.data_offset,
                    out_res.is_end_card,
                    out_res.status,
                    out_res.comment_start,
                    out_res.value_is_string,
                    out_res.value_end,
                    out_res.value_start,
                    out_res.has_value,
                    out_res.key_text,
                    out_res.clean_char};
  assign m_tlast = out_res.card_done;

endmodule

FILE: dv/fits_header_card_parser_tb.sv
// ----------------------------------------------------------------------------
// fits_header_card_parser_tb - self-checking bench for the FITS card parser
// Streams whole 80-byte cards into the parser, predicts every output word
// with a cycle-free card scanner, and compares each word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fits_header_card_parser_tb;
  import fhcp_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int PRINT_LIMIT  = 100;
  localparam int RANDOM_BYTES = 160;

  localparam string KEY_CHARS  = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_";
  localparam string SEP_CHARS  = " =xA'/";
  localparam string BARE_CHARS = "0123456789+-.EDTF  ='";
  localparam string STR_CHARS  = "abcXYZ 019/=.-";
  localparam string JUNK_CHARS = "XY9=.'";

  // One output word as the scanner predicts it.
  typedef struct packed {
    logic [6:0]  ch;
    logic        done;
    logic [63:0] key;
    logic        has;
    logic [6:0]  vstart;
    logic [6:0]  vend;
    logic        vstr;
    logic [6:0]  cstart;
    logic [1:0]  stat;
    logic        is_end;
    logic [31:0] offset;
  } card_word_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;
  logic         m_tlast;

  // steady = 1 turns off idling on both sides
  logic         steady = 1'b0;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  card_word_t   pending_words[$];
  logic [7:0]   card_buf [0:79];

  // Card scanner state
  logic [6:0]   scan_col;
  logic [63:0]  scan_key;
  phase_t       scan_phase;
  logic         eq_ok;
  logic [6:0]   val_start;
  logic [6:0]   val_last;
  logic [6:0]   val_end;
  logic [6:0]   cmt_col;
  status_t      card_stat;
  logic [5:0]   cards_in_blk;
  logic [20:0]  blk_count;

  fits_header_card_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sink: drop m_tready about a third of the time unless running steady.
  always @(negedge clk) begin
    m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 32);
  end

  // --------------------------------------------------------------------------
  // Card scanner
  // --------------------------------------------------------------------------

  // Clear the per-card state; block counters survive.
  function automatic void clear_scan();
    scan_col   = '0;
    scan_key   = '0;
    scan_phase = PH_KEY;
    eq_ok      = 1'b0;
    val_start  = '0;
    val_last   = '0;
    val_end    = '0;
    cmt_col    = COL_NONE;
    card_stat  = ST_OK;
  endfunction

  // First non-space after a closing quote: a slash opens the comment,
  // anything else is trailing garbage.
  function automatic void after_string(logic [6:0] c, logic [6:0] col);
    if (c == CH_SLASH) begin
      cmt_col    = col + 7'd1;
      scan_phase = PH_DONE_STR;
    end else if (c != CH_SPACE) begin
      card_stat  = ST_TRAILING;
      scan_phase = PH_DONE_STR;
    end else begin
      scan_phase = PH_AFTER;
    end
  endfunction

  // Advance the scanner by one raw byte and return the word it produces.
  function automatic card_word_t scan_byte(logic [7:0] raw);
    card_word_t  w;
    logic [6:0]  c;
    logic [6:0]  col;
    logic        has;
    logic        str;
    logic [63:0] off;
    logic [63:0] lim;
    w   = '0;
    c   = (raw < CH_LOW || raw > CH_HIGH) ? CH_SPACE : raw[6:0];
    col = scan_col;
    w.ch = c;

    if (col < COL_EQ_FIRST) begin
      scan_key = {scan_key[55:0], 1'b0, c};
    end else if (col == COL_EQ_FIRST) begin
      if (c == CH_EQUALS) begin
        eq_ok = 1'b1;
      end else if (c == CH_SPACE) begin
        eq_ok = 1'b0;
      end else begin
        eq_ok      = 1'b0;
        scan_phase = PH_DONE;
      end
    end else if (col == COL_EQ_SECOND) begin
      // only "= " or " =" across columns 8..9 opens a value
      if (scan_phase == PH_KEY) begin
        eq_ok      = eq_ok ? (c == CH_SPACE) : (c == CH_EQUALS);
        scan_phase = eq_ok ? PH_SEEK : PH_DONE;
      end
    end else begin
      case (scan_phase)
        PH_SEEK: begin
          if (c != CH_SPACE) begin
            val_start = col;
            if (c == CH_QUOTE) begin
              scan_phase = PH_STR;
            end else begin
              scan_phase = PH_BARE;
              val_last   = col;
            end
          end
        end
        PH_BARE: begin
          if (c == CH_SLASH) begin
            val_end    = val_last;
            cmt_col    = col + 7'd1;
            scan_phase = PH_DONE;
          end else if (c != CH_SPACE) begin
            val_last = col;
          end
        end
        PH_STR: begin
          if (c == CH_QUOTE) scan_phase = PH_QUOTE;
        end
        PH_QUOTE: begin
          // a second quote right away is an escaped quote
          if (c == CH_QUOTE) begin
            scan_phase = PH_STR;
          end else begin
            val_end = col - 7'd1;
            after_string(c, col);
          end
        end
        PH_AFTER: after_string(c, col);
        default: ;
      endcase
    end

    if (col != COL_LAST) begin
      scan_col = col + 7'd1;
      return w;
    end

    // Last column: summarize the card.
    has = 1'b0;
    str = 1'b0;
    case (scan_phase)
      PH_BARE: begin
        val_end = val_last;
        has     = 1'b1;
      end
      PH_STR: begin
        card_stat = ST_UNTERM;
        val_end   = COL_LAST;
        cmt_col   = COL_NONE;
        has       = 1'b1;
        str       = 1'b1;
      end
      PH_QUOTE: begin
        val_end = COL_LAST;
        has     = 1'b1;
        str     = 1'b1;
      end
      PH_AFTER, PH_DONE_STR: begin
        has = 1'b1;
        str = 1'b1;
      end
      PH_DONE: has = eq_ok;
      default: has = 1'b0;
    endcase
    if (!eq_ok) has = 1'b0;
    if (card_stat == ST_TRAILING) cmt_col = COL_NONE;

    w.done = 1'b1;
    w.key  = scan_key;
    w.has  = has;
    if (has) begin
      w.vstart = val_start;
      w.vend   = val_end;
      w.vstr   = str;
      w.cstart = cmt_col;
      w.stat   = card_stat;
    end else begin
      w.cstart = COL_NONE;
    end

    w.is_end = (scan_key == END_KEY);
    if (w.is_end) begin
      lim = (OFFSET_BITS >= 32) ? 64'hFFFF_FFFF : ((64'd1 << OFFSET_BITS) - 64'd1);
      off = (64'(blk_count) + 64'd1) * 64'(BLOCK_BYTES);
      if (blk_count == BLOCK_MAX || off > lim) off = lim;
      w.offset     = off[31:0];
      cards_in_blk = '0;
      blk_count    = '0;
    end else if (cards_in_blk == CIB_LAST) begin
      cards_in_blk = '0;
      if (blk_count != BLOCK_MAX) blk_count = blk_count + 21'd1;
    end else begin
      cards_in_blk = cards_in_blk + 6'd1;
    end
    clear_scan();
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      if (mismatch_count < PRINT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every output word with the oldest prediction.
  always @(posedge clk) begin : watch_results
    card_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        if (mismatch_count < PRINT_LIMIT)
          $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("clean_char",      64'(want.ch),     64'(m_tdata[6:0]));
        check_field("card_done",       64'(want.done),   64'(m_tlast));
        check_field("key_text",        want.key,         m_tdata[70:7]);
        check_field("has_value",       64'(want.has),    64'(m_tdata[71]));
        check_field("value_start",     64'(want.vstart), 64'(m_tdata[78:72]));
        check_field("value_end",       64'(want.vend),   64'(m_tdata[85:79]));
        check_field("value_is_string", 64'(want.vstr),   64'(m_tdata[86]));
        check_field("comment_start",   64'(want.cstart), 64'(m_tdata[93:87]));
        check_field("status",          64'(want.stat),   64'(m_tdata[95:94]));
        check_field("is_end_card",     64'(want.is_end), 64'(m_tdata[96]));
        check_field("data_offset",     64'(want.offset), 64'(m_tdata[128:97]));
        check_field("tdata padding",   '0,               64'(m_tdata[135:129]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Send one byte; idle beforehand at random, predict once it is taken.
  task automatic send_byte(logic [7:0] b);
    card_word_t w;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    w = scan_byte(b);
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic send_card();
    for (int i = 0; i < 80; i++) send_byte(card_buf[i]);
  endtask

  function automatic void blank_card();
    foreach (card_buf[i]) card_buf[i] = " ";
  endfunction

  // Write a character and return the next column; anything past 79 is dropped.
  function automatic int put_char(int col, logic [7:0] ch);
    if (col < 80) card_buf[col] = ch;
    return col + 1;
  endfunction

  function automatic void put_text(int col, string txt);
    for (int i = 0; i < txt.len(); i++) void'(put_char(col + i, txt[i]));
  endfunction

  function automatic logic [7:0] pick_char(string chars);
    return chars[$urandom_range(chars.len() - 1)];
  endfunction

  function automatic int put_bare(int col);
    int n;
    n = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) col = put_char(col, pick_char(BARE_CHARS));
    return col;
  endfunction

  // Quoted value with doubled quotes sprinkled in; now and then left open.
  function automatic int put_string(int col);
    int n;
    n   = $urandom_range(0, 15);
    col = put_char(col, "'");
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0) begin
        col = put_char(col, "'");
        col = put_char(col, "'");
      end else begin
        col = put_char(col, pick_char(STR_CHARS));
      end
    end
    if ($urandom_range(9) != 0) col = put_char(col, "'");
    return col;
  endfunction

  // Keyword, equals columns, bare, quoted or no value, then comment, garbage or nothing.
  function automatic void build_random_card();
    int n;
    int col;
    int pick;
    blank_card();
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) card_buf[i] = pick_char(KEY_CHARS);
    pick = $urandom_range(99);
    if (pick < 80) begin
      put_text(8, "= ");
    end else if (pick < 88) begin
      put_text(8, " =");
    end else begin
      card_buf[8] = pick_char(SEP_CHARS);
      card_buf[9] = pick_char(SEP_CHARS);
    end
    col  = ($urandom_range(9) == 0) ? $urandom_range(10, 79) : $urandom_range(10, 30);
    pick = $urandom_range(99);
    if (pick < 45) col = put_bare(col);
    else if (pick < 90) col = put_string(col);
    col  = col + $urandom_range(0, 3);
    pick = $urandom_range(99);
    if (pick >= 40 && pick < 80) begin
      col = put_char(col, "/");
      n   = $urandom_range(0, 20);
      for (int i = 0; i < n; i++) col = put_char(col, 8'($urandom_range(32, 126)));
    end else if (pick >= 80) begin
      col = put_char(col, pick_char(JUNK_CHARS));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-written cards covering every parse path and corner column.
  task automatic test_directed();
    steady = 1'b0;
    // bare logical value, then bare value with comment
    blank_card(); put_text(0, "SIMPLE  =                    T"); send_card();
    blank_card(); put_text(0, "BITPIX  =                   16 / bits"); send_card();
    // equals in column 9 after a space
    blank_card(); put_text(0, "NAXIS    = 2"); send_card();
    // escaped quote, slash right after the closing quote
    blank_card(); put_text(0, "OBJECT  = 'O''HARA'/ name"); send_card();
    blank_card(); put_text(0, "EMPTY   = ''"); send_card();
    // open string runs to the end of the card
    blank_card(); put_text(0, "ORIGIN  = 'no closing quote"); send_card();
    // garbage after the string
    blank_card(); put_text(0, "TELESCOP= 'X'  junk / c"); send_card();
    // closing quote in the last column
    blank_card(); put_text(0, "LONGSTR = 'abc"); card_buf[79] = "'"; send_card();
    // doubled quote at columns 78..79 leaves the string open
    blank_card(); put_text(0, "LONGSTR = 'abc"); put_text(78, "''"); send_card();
    // slash in the last column gives an empty comment
    blank_card(); put_text(0, "VAL     =  42"); card_buf[79] = "/"; send_card();
    // value that is only column 79
    blank_card(); put_text(0, "LASTCOL = "); card_buf[79] = "9"; send_card();
    // equals with nothing after it
    blank_card(); put_text(0, "NOVALUE = "); send_card();
    // failing equals tests
    blank_card(); put_text(0, "BADEQ   ==1"); send_card();
    blank_card(); put_text(0, "BADEQ   x= 1"); send_card();
    blank_card(); put_text(0, "COMMENT   plain text / not a value"); send_card();
    // bare value that opens with a slash
    blank_card(); put_text(0, "SLASHV  = /abc / c"); send_card();
    // unprintable extremes: zeros, then all ones, then mixed control and DEL
    foreach (card_buf[i])
      card_buf[i] = (i < 27) ? 8'h00 : (i < 54) ? 8'hFF : (i[0] ? 8'h7F : 8'h1F);
    send_card();
    // END padded with control bytes still cleans to an END key
    blank_card(); put_text(0, "END");
    for (int i = 3; i < 8; i++) card_buf[i] = 8'h00;
    send_card();
    // near miss, then a real END right after the last one
    blank_card(); put_text(0, "END    X"); send_card();
    blank_card(); put_text(0, "END"); send_card();
  endtask

  // END right after END, then a short header rounded up to one block,
  // no idling at all.
  task automatic test_block_rounding();
    steady = 1'b1;
    blank_card(); put_text(0, "END"); send_card();
    build_random_card();
    send_card();
    blank_card(); put_text(0, "END"); send_card();
    steady = 1'b0;
  endtask

  // Mostly well-formed cards with random content, plus END and noise cards.
  task automatic test_random();
    int sent;
    int pick;
    sent   = 0;
    steady = 1'b0;
    while (sent < RANDOM_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        blank_card();
        put_text(0, "END");
        if ($urandom_range(1)) put_text($urandom_range(10, 70), "/ x");
      end else if (pick < 20) begin
        foreach (card_buf[i]) card_buf[i] = 8'($urandom_range(255));
        if ($urandom_range(1)) put_text(0, "NOISE   = ");
      end else begin
        build_random_card();
        if ($urandom_range(99) < 15)
          repeat ($urandom_range(1, 4)) card_buf[$urandom_range(79)] = 8'($urandom_range(255));
      end
      send_card();
      sent += 80;
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    m_tready = 1'b0;
    clear_scan();
    cards_in_blk = '0;
    blk_count    = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_block_rounding();
    test_random();

    @(negedge clk);
    s_tvalid <= 1'b0;
    // drain, then give the pipeline time to show any stray word
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
